// ----- src/mso_pkg.sv -----
// ----------------------------------------------------------------------------
// mso_pkg: motor state observer shared definitions
// Widths, step codes, register indexes, the config bundle, the multiplier
// request/response bundles and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package mso_pkg;

  localparam int COEF_FRAC_BITS = 24;
  localparam int DATA_W         = 32;
  localparam int VOLT_W         = 16;
  localparam int TICK_W         = 31;
  localparam int OP_W           = DATA_W + 1;
  localparam int PROD_W         = 2 * OP_W;
  localparam int RND_W          = PROD_W + 1;
  // three terms, each below 2^(PROD_W-1-COEF_FRAC_BITS+1), plus margin
  localparam int ACC_W          = PROD_W - COEF_FRAC_BITS + 3;
  localparam int CFG_IDX_W      = 8;
  localparam int STEP_W         = 3;

  localparam int MEAS_SHIFT     = COEF_FRAC_BITS - 16;
  localparam int VOLT_SHIFT     = COEF_FRAC_BITS - 8;

  typedef enum logic [STEP_W-1:0] {
    STEP_MEAS,
    STEP_PRED_ANGLE,
    STEP_DECAY,
    STEP_VOLT,
    STEP_CORR_ANGLE,
    STEP_CORR_SPEED
  } step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME,
    REG_SPEED_DECAY,
    REG_VOLT_GAIN,
    REG_ANGLE_GAIN,
    REG_SPEED_GAIN,
    REG_RAD_PER_TICK
  } reg_idx_t;

  localparam logic signed [DATA_W-1:0] RST_STEP_TIME    = 32'sd16777;
  localparam logic signed [DATA_W-1:0] RST_SPEED_DECAY  = 32'sd16777216;
  localparam logic signed [DATA_W-1:0] RST_VOLT_GAIN    = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_ANGLE_GAIN   = 32'sd29834169;
  localparam logic signed [DATA_W-1:0] RST_SPEED_GAIN   = 32'sd573044968;
  localparam logic [TICK_W-1:0]        RST_RAD_PER_TICK = 31'd25736;

  typedef struct packed {
    logic signed [DATA_W-1:0] step_time;
    logic signed [DATA_W-1:0] speed_decay;
    logic signed [DATA_W-1:0] volt_gain;
    logic signed [DATA_W-1:0] angle_gain;
    logic signed [DATA_W-1:0] speed_gain;
    logic [TICK_W-1:0]        rad_per_tick;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    step_t                  step;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     valid;
    step_t                    step;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  // round half up, then arithmetic shift right by s
  function automatic logic signed [RND_W-1:0] round_shift(
    input logic signed [RND_W-1:0] x,
    input int unsigned             s
  );
    logic signed [RND_W-1:0] half;
    half = '0;
    if (s == 0) begin
      return x;
    end
    half = RND_W'(1) <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [RND_W-1:0] x);
    logic [RND_W-DATA_W:0] hi;
    hi = x[RND_W-1:DATA_W-1];
    if ((&hi) || (~|hi)) begin
      return x[DATA_W-1:0];
    end
    return x[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

// ----- src/mso_if.sv -----
// ----------------------------------------------------------------------------
// mso_if: motor state observer channel interfaces
// Sample input, estimate output and configuration write channels.
// ----------------------------------------------------------------------------
interface mso_in_if;
  import mso_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] encoder_count;
  logic signed [VOLT_W-1:0] motor_volts;
  modport source (output valid, encoder_count, motor_volts, input ready);
  modport sink   (input valid, encoder_count, motor_volts, output ready);
endinterface

interface mso_out_if;
  import mso_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] angle_estimate;
  logic signed [DATA_W-1:0] speed_estimate;
  modport source (output valid, angle_estimate, speed_estimate, input ready);
  modport sink   (input valid, angle_estimate, speed_estimate, output ready);
endinterface

interface mso_cfg_if;
  import mso_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/mso_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mso_cfg_regs: observer coefficient registers
// Decodes configuration write beats into the coefficient bundle.
// ----------------------------------------------------------------------------
module mso_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  mso_cfg_if.sink       cfg,
  output mso_pkg::cfg_t coef
);
  import mso_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.step_time    <= RST_STEP_TIME;
      coef.speed_decay  <= RST_SPEED_DECAY;
      coef.volt_gain    <= RST_VOLT_GAIN;
      coef.angle_gain   <= RST_ANGLE_GAIN;
      coef.speed_gain   <= RST_SPEED_GAIN;
      coef.rad_per_tick <= RST_RAD_PER_TICK;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STEP_TIME:    coef.step_time    <= cfg.wdata;
        REG_SPEED_DECAY:  coef.speed_decay  <= cfg.wdata;
        REG_VOLT_GAIN:    coef.volt_gain    <= cfg.wdata;
        REG_ANGLE_GAIN:   coef.angle_gain   <= cfg.wdata;
        REG_SPEED_GAIN:   coef.speed_gain   <= cfg.wdata;
        REG_RAD_PER_TICK: coef.rad_per_tick <= cfg.wdata[TICK_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// ----- src/mso_mul.sv -----
// ----------------------------------------------------------------------------
// mso_mul: shared signed multiplier
// One 33x33 signed multiply per cycle with a registered product and tag.
// ----------------------------------------------------------------------------
module mso_mul (
  input  logic              clk,
  input  logic              rst,
  input  mso_pkg::mul_req_t req,
  output mso_pkg::mul_rsp_t rsp
);
  import mso_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= req.valid;
    end
    rsp.step <= req.step;
    rsp.prod <= req.a * req.b;
  end

endmodule

// ----- src/mso_core.sv -----
// ----------------------------------------------------------------------------
// mso_core: observer sequencer and accumulators
// Issues the six products of one sample to the shared multiplier, rounds
// and accumulates them, then commits the saturated estimates.
// ----------------------------------------------------------------------------
module mso_core (
  input  logic              clk,
  input  logic              rst,
  input  mso_pkg::cfg_t     coef,
  mso_in_if.sink            sample,
  mso_out_if.source         estimate,
  output mso_pkg::mul_req_t req,
  input  mso_pkg::mul_rsp_t rsp
);
  import mso_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t                   state;
  step_t                    issue_step;
  logic signed [DATA_W-1:0] count_q;
  logic signed [VOLT_W-1:0] volts_q;
  logic signed [VOLT_W-1:0] prev_volts;
  logic                     primed;
  logic signed [DATA_W-1:0] angle_state;
  logic signed [DATA_W-1:0] speed_state;
  logic signed [OP_W-1:0]   err;
  logic signed [ACC_W-1:0]  acc_a;
  logic signed [ACC_W-1:0]  acc_s;
  logic                     out_valid;
  logic signed [DATA_W-1:0] angle_out;
  logic signed [DATA_W-1:0] speed_out;

  logic signed [RND_W-1:0]  prod_ext;
  logic signed [RND_W-1:0]  rounded;
  logic signed [DATA_W-1:0] meas;
  logic signed [DATA_W-1:0] angle_sat;
  logic signed [DATA_W-1:0] speed_sat;
  logic                     accept;
  logic                     slot_free;
  logic                     commit;

  assign sample.ready            = (state == ST_IDLE);
  assign accept                  = sample.valid && sample.ready;
  assign estimate.valid          = out_valid;
  assign estimate.angle_estimate = angle_out;
  assign estimate.speed_estimate = speed_out;
  assign slot_free               = !out_valid || estimate.ready;
  // the last product lands from the multiplier register in the cycle after issue; commit once it is folded in
  assign commit                  = (state == ST_FINISH) && !rsp.valid && slot_free;

  // operand select
  always_comb begin
    req.valid = (state == ST_RUN);
    req.step  = issue_step;
    unique case (issue_step)
      STEP_MEAS: begin
        req.a = OP_W'(count_q);
        req.b = OP_W'(coef.rad_per_tick);
      end
      STEP_PRED_ANGLE: begin
        req.a = OP_W'(coef.step_time);
        req.b = OP_W'(speed_state);
      end
      STEP_DECAY: begin
        req.a = OP_W'(coef.speed_decay);
        req.b = OP_W'(speed_state);
      end
      STEP_VOLT: begin
        req.a = OP_W'(coef.volt_gain);
        req.b = OP_W'(prev_volts);
      end
      STEP_CORR_ANGLE: begin
        req.a = OP_W'(coef.angle_gain);
        req.b = err;
      end
      STEP_CORR_SPEED: begin
        req.a = OP_W'(coef.speed_gain);
        req.b = err;
      end
      default: begin
        req.a = '0;
        req.b = '0;
      end
    endcase
  end

  // rounding of the returned product
  always_comb begin
    prod_ext = RND_W'(rsp.prod);
    unique case (rsp.step)
      STEP_MEAS: rounded = round_shift(prod_ext, MEAS_SHIFT);
      STEP_VOLT: rounded = round_shift(prod_ext, VOLT_SHIFT);
      default:   rounded = round_shift(prod_ext, COEF_FRAC_BITS);
    endcase
    meas      = sat32(rounded);
    angle_sat = sat32(RND_W'(acc_a));
    speed_sat = sat32(RND_W'(acc_s));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issue_step  <= STEP_MEAS;
      primed      <= 1'b0;
      prev_volts  <= '0;
      angle_state <= '0;
      speed_state <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && estimate.ready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count_q    <= sample.encoder_count;
            volts_q    <= sample.motor_volts;
            issue_step <= STEP_MEAS;
            state      <= ST_RUN;
            if (!primed) begin
              prev_volts <= sample.motor_volts;
              primed     <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (issue_step == STEP_CORR_SPEED) begin
            state <= ST_FINISH;
          end else begin
            issue_step <= step_t'(issue_step + 1'b1);
          end
        end
        ST_FINISH: begin
          if (commit) begin
            angle_state <= angle_sat;
            speed_state <= speed_sat;
            angle_out   <= angle_sat;
            speed_out   <= speed_sat;
            out_valid   <= 1'b1;
            prev_volts  <= volts_q;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // fold in the product issued last cycle
      if (rsp.valid) begin
        case (rsp.step)
          STEP_MEAS:       err   <= OP_W'(meas) - OP_W'(angle_state);
          STEP_PRED_ANGLE: acc_a <= ACC_W'(angle_state) + rounded[ACC_W-1:0];
          STEP_DECAY:      acc_s <= rounded[ACC_W-1:0];
          STEP_VOLT:       acc_s <= acc_s + rounded[ACC_W-1:0];
          STEP_CORR_ANGLE: acc_a <= acc_a + rounded[ACC_W-1:0];
          STEP_CORR_SPEED: acc_s <= acc_s + rounded[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- src/motor_state_observer.sv -----
// ----------------------------------------------------------------------------
// motor_state_observer: fixed-gain two-state DC motor observer
// Scales an encoder count to an angle, predicts angle and speed from the
// stored estimates and the previous drive voltage, and corrects both by
// gains on the angle error. State Q16.16, coefficients Q8.24, volts Q8.8.
// ----------------------------------------------------------------------------
//
//  channel   | dir | beat contents
//  ----------+-----+---------------------------------------------
//  sample    | in  | encoder_count (s32), motor_volts (s16 Q8.8)
//  estimate  | out | angle_estimate (s32 Q16.16), speed_estimate (s32 Q16.16)
//  cfg       | in  | index (8b register number), wdata (32b)
//
//  Each sample runs from its accept edge to the earliest next accept:
//  six products through the single 33x33 multiplier, the fold of the last
//  product, the commit (held while a result waits unread), then an idle
//  state with ready high. The estimate beat is registered at the commit.
//  Synchronous reset restores the coefficient defaults, zeroes the state
//  and clears the primed flag. A result waiting in the output register
//  does not block the next sample; only a second result waits for it.
//  cfg is always ready; write it only while the block is idle.
//
module motor_state_observer (
  input  logic      clk,
  input  logic      rst,
  mso_in_if.sink    sample,
  mso_out_if.source estimate,
  mso_cfg_if.sink   cfg
);
  import mso_pkg::*;

  cfg_t     coef;
  mul_req_t req;
  mul_rsp_t rsp;

  // coefficient registers
  mso_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  // shared multiplier, one product per cycle
  mso_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // sequencer, accumulators, estimate state and output register
  mso_core u_core (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .sample   (sample),
    .estimate (estimate),
    .req      (req),
    .rsp      (rsp)
  );

  // a sample beat closes the input for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample accepted back to back");

  // a new result only appears at the end of a busy sequence
  assert property (@(posedge clk) disable iff (rst)
    $rose(estimate.valid) |-> !$past(sample.ready))
    else $error("result raised while idle");

  // a new result is not raised before the multiplier sequence has run
  assert property (@(posedge clk) disable iff (rst)
    $rose(estimate.valid) |-> !$past(sample.ready, 6))
    else $error("result raised too early");

endmodule
